@@ hw/rtl/lzwc_pkg.sv @@
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared types and constants of the LZW byte compressor: code widths, the
// dictionary size and the layout of one dictionary node.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lzwc_pkg;

  localparam int CODE_W     = 16;
  localparam int KEY_W      = 8;
  localparam int CODE_LIMIT = 65535;            // dictionary entries
  localparam int ADDR_W     = $clog2(CODE_LIMIT);
  localparam int ROOT_COUNT = 256;
  localparam int ROOT_W     = 8;

  localparam logic [CODE_W-1:0] NONE_CODE  = 16'hFFFF;
  localparam logic [CODE_W-1:0] ROOT_CODES = 16'd256;
  localparam logic [CODE_W-1:0] LIMIT_CODE = 16'(CODE_LIMIT);
  localparam logic [KEY_W-1:0]  KEY_FLIP   = 8'h80;

  // One dictionary node: byte key, first child, left and right siblings
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] left;
    logic [CODE_W-1:0] right;
  } node_t;

  localparam int NODE_W = $bits(node_t);

endpackage

`default_nettype wire

@@ hw/rtl/lzwc_ram.sv @@
// ----------------------------------------------------------------------------
// lzwc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data, ready in the cycle after the read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lzw_byte_compressor.sv @@
// Flow: a byte walks the dictionary from the prefix node, one node read per cycle;
//   a miss writes the new node, then emits the prefix code once the output is free;
//   a final byte also flushes the prefix. A stream-start byte only sets the prefix;
//   a full dictionary is cleared and the prefix emitted. One byte is taken at a time.
// Reset: synchronous; dictionary roots are restored at once by 256 root valid
//   flags, so the block takes items as soon as reset is released.
// ----------------------------------------------------------------------------
// lzw_byte_compressor
// LZW compressor with 16-bit codes. The dictionary is a tree of sibling
// search trees held in one RAM; each byte walks it from the prefix node.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzw_byte_compressor
  import lzwc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KEY_W-1:0]  in_data_byte,
  input  wire logic              in_last_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [CODE_W-1:0] out_code_out,
  output logic                   out_last_code
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_WR_NODE,
    S_EMIT_MISS,
    S_EMIT_LAST
  } state_t;

  state_t state_r, state_nxt;

  logic [CODE_W-1:0]     prefix_r, prefix_nxt;
  logic [CODE_W-1:0]     next_free_r, next_free_nxt;
  logic [ROOT_COUNT-1:0] root_vld_r, root_vld_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]     out_code_r, out_code_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic                  last_r, last_nxt;
  logic [CODE_W-1:0]     cur_r, cur_nxt;
  logic                  is_pre_r, is_pre_nxt;

  // Dictionary RAM ports
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  node_t             wr_node, rd_node_raw, node;
  logic [NODE_W-1:0] rd_word;

  logic              in_take, out_free;
  logic [KEY_W-1:0]  in_key;
  logic [CODE_W-1:0] link;
  logic              link_live;

  lzwc_ram #(
    .WIDTH(NODE_W),
    .DEPTH(CODE_LIMIT)
  ) u_dict (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_node),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_word)
  );

  assign rd_node_raw   = node_t'(rd_word);
  assign in_stall      = (state_r != S_IDLE);
  assign in_take       = in_valid && !in_stall;
  assign in_key        = in_data_byte ^ KEY_FLIP;
  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_code_out  = out_code_r;
  assign out_last_code = out_last_r;

  // Node just read; a root not written since the last clear reads as reset
  always_comb begin
    node = rd_node_raw;
    if ((cur_r[CODE_W-1:ROOT_W] == '0) && !root_vld_r[cur_r[ROOT_W-1:0]]) begin
      node.key   = cur_r[KEY_W-1:0];
      node.first = NONE_CODE;
      node.left  = NONE_CODE;
      node.right = NONE_CODE;
    end
  end

  // Link to follow from the node just read
  always_comb begin
    if (is_pre_r) begin
      link = node.first;
    end else if (key_r < node.key) begin
      link = node.left;
    end else begin
      link = node.right;
    end
  end

  assign link_live = (link < next_free_r);

  // Next-state and datapath control
  always_comb begin
    state_nxt     = state_r;
    prefix_nxt    = prefix_r;
    next_free_nxt = next_free_r;
    root_vld_nxt  = root_vld_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    cur_nxt       = cur_r;
    is_pre_nxt    = is_pre_r;
    wr_en         = 1'b0;
    wr_addr       = cur_r[ADDR_W-1:0];
    wr_node       = node;
    rd_en         = 1'b0;
    rd_addr       = prefix_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          key_nxt  = in_key;
          last_nxt = in_last_byte;
          if (prefix_r == NONE_CODE) begin
            // stream start: the byte only sets the prefix
            prefix_nxt = {{(CODE_W-KEY_W){1'b0}}, in_key};
            state_nxt  = in_last_byte ? S_EMIT_LAST : S_IDLE;
          end else if (next_free_r >= LIMIT_CODE) begin
            // full dictionary: clear, then emit the prefix
            root_vld_nxt  = '0;
            next_free_nxt = ROOT_CODES;
            state_nxt     = S_EMIT_MISS;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = prefix_r[ADDR_W-1:0];
            cur_nxt    = prefix_r;
            is_pre_nxt = 1'b1;
            state_nxt  = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        if (!is_pre_r && (key_r == node.key)) begin
          // hit: prefix extends
          prefix_nxt = cur_r;
          state_nxt  = last_r ? S_EMIT_LAST : S_IDLE;
        end else if (link_live) begin
          rd_en      = 1'b1;
          rd_addr    = link[ADDR_W-1:0];
          cur_nxt    = link;
          is_pre_nxt = 1'b0;
        end else begin
          // miss: hang the new code on this node
          wr_en = 1'b1;
          if (is_pre_r) begin
            wr_node.first = next_free_r;
          end else if (key_r < node.key) begin
            wr_node.left = next_free_r;
          end else begin
            wr_node.right = next_free_r;
          end
          if (cur_r[CODE_W-1:ROOT_W] == '0) begin
            root_vld_nxt[cur_r[ROOT_W-1:0]] = 1'b1;
          end
          state_nxt = S_WR_NODE;
        end
      end

      S_WR_NODE: begin
        wr_en         = 1'b1;
        wr_addr       = next_free_r[ADDR_W-1:0];
        wr_node.key   = key_r;
        wr_node.first = NONE_CODE;
        wr_node.left  = NONE_CODE;
        wr_node.right = NONE_CODE;
        next_free_nxt = next_free_r + 16'd1;
        state_nxt     = S_EMIT_MISS;
      end

      S_EMIT_MISS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = prefix_r;
          out_last_nxt  = 1'b0;
          prefix_nxt    = {{(CODE_W-KEY_W){1'b0}}, key_r};
          state_nxt     = last_r ? S_EMIT_LAST : S_IDLE;
        end
      end

      S_EMIT_LAST: begin
        // flush the prefix and start a fresh stream
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = prefix_r;
          out_last_nxt  = 1'b1;
          prefix_nxt    = NONE_CODE;
          root_vld_nxt  = '0;
          next_free_nxt = ROOT_CODES;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prefix_r    <= NONE_CODE;
      next_free_r <= ROOT_CODES;
      root_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prefix_r    <= prefix_nxt;
      next_free_r <= next_free_nxt;
      root_vld_r  <= root_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
    key_r      <= key_nxt;
    last_r     <= last_nxt;
    cur_r      <= cur_nxt;
    is_pre_r   <= is_pre_nxt;
  end

endmodule

`default_nettype wire
